### hdl/mtf_pkg.sv
`default_nettype none

package mtf_pkg;

  localparam int LIST_DEPTH = 64;
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int KEY_W      = 32;
  localparam int POS_W      = 6;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef struct packed {
    logic latch;
    logic ptr_inc;
    logic ptr_dec;
    logic rd_cur;
    logic rd_prev;
    logic wr_tail;
    logic wr_shift;
    logic wr_front;
    logic res_hit;
    logic res_rej;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_load;
    logic full;
    logic empty;
    logic match;
    logic last;
    logic ptr_zero;
    logic ptr_one;
  } status_t;

endpackage

`default_nettype wire

### hdl/mtf_datapath.sv
`default_nettype none

module mtf_datapath (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  mtf_pkg::cmd_t                cmd_i,
  output mtf_pkg::status_t             status_o,
  input  wire                          in_kind_i,
  input  wire signed [mtf_pkg::KEY_W-1:0] in_key_value_i,
  output logic                         out_found_o,
  output logic [mtf_pkg::POS_W-1:0]    out_hit_position_o,
  output logic                         out_load_rejected_o
);

  logic [mtf_pkg::KEY_W-1:0] mem [mtf_pkg::LIST_DEPTH];
  logic [mtf_pkg::KEY_W-1:0] rdata_q;
  logic [mtf_pkg::KEY_W-1:0] key_q;
  logic                      kind_q;
  logic [mtf_pkg::IDX_W-1:0] ptr_q;
  logic [mtf_pkg::CNT_W-1:0] fill_q, fill_d;
  logic                      res_found_q;
  logic [mtf_pkg::POS_W-1:0] res_pos_q;
  logic                      res_rej_q;
  logic [mtf_pkg::IDX_W-1:0] ptr_prev;
  logic [mtf_pkg::CNT_W-1:0] ptr_next_ext;

  assign ptr_prev     = ptr_q - 1'b1;
  assign ptr_next_ext = mtf_pkg::CNT_W'(ptr_q) + 1'b1;

  always_comb begin
    fill_d = fill_q;
    if (cmd_i.wr_tail) begin
      fill_d = fill_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_tail) begin
      mem[fill_q[mtf_pkg::IDX_W-1:0]] <= key_q;
    end else if (cmd_i.wr_shift) begin
      mem[ptr_q] <= rdata_q;
    end else if (cmd_i.wr_front) begin
      mem[0] <= key_q;
    end
    if (cmd_i.rd_cur) begin
      rdata_q <= mem[ptr_q];
    end else if (cmd_i.rd_prev) begin
      rdata_q <= mem[ptr_prev];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      key_q       <= in_key_value_i;
      kind_q      <= in_kind_i;
      ptr_q       <= '0;
      res_found_q <= 1'b0;
      res_pos_q   <= '0;
      res_rej_q   <= 1'b0;
    end else begin
      if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + 1'b1;
      end else if (cmd_i.ptr_dec) begin
        ptr_q <= ptr_prev;
      end
      if (cmd_i.res_hit) begin
        res_found_q <= 1'b1;
        res_pos_q   <= mtf_pkg::POS_W'(ptr_q);
      end
      if (cmd_i.res_rej) begin
        res_rej_q <= 1'b1;
      end
    end
    if (cmd_i.out_load) begin
      out_found_o         <= res_found_q;
      out_hit_position_o  <= res_pos_q;
      out_load_rejected_o <= res_rej_q;
    end
  end

  assign status_o.is_load  = (kind_q == mtf_pkg::KIND_LOAD);
  assign status_o.full     = (fill_q == mtf_pkg::CNT_W'(mtf_pkg::LIST_DEPTH));
  assign status_o.empty    = (fill_q == '0);
  assign status_o.match    = (rdata_q == key_q);
  assign status_o.last     = (ptr_next_ext == fill_q);
  assign status_o.ptr_zero = (ptr_q == '0);
  assign status_o.ptr_one  = (ptr_q == mtf_pkg::IDX_W'(1));

endmodule

`default_nettype wire

### hdl/mtf_controller.sv
`default_nettype none

module mtf_controller (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  input  mtf_pkg::status_t status_i,
  output mtf_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DISP  = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_CMP   = 3'd3;
  localparam logic [2:0] ST_SH_RD = 3'd4;
  localparam logic [2:0] ST_SH_WR = 3'd5;
  localparam logic [2:0] ST_FRONT = 3'd6;
  localparam logic [2:0] ST_PUSH  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DISP;
        end
      end
      ST_DISP: begin
        if (status_i.is_load) begin
          if (status_i.full) begin
            cmd_o.res_rej = 1'b1;
          end else begin
            cmd_o.wr_tail = 1'b1;
          end
          state_d = ST_PUSH;
        end else if (status_i.empty) begin
          state_d = ST_PUSH;
        end else begin
          cmd_o.rd_cur = 1'b1;
          state_d      = ST_CMP;
        end
      end
      ST_RD: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = ST_CMP;
      end
      ST_CMP: begin
        if (status_i.match) begin
          cmd_o.res_hit = 1'b1;
          if (status_i.ptr_zero) begin
            state_d = ST_PUSH;
          end else begin
            cmd_o.rd_prev = 1'b1;
            state_d       = ST_SH_WR;
          end
        end else if (status_i.last) begin
          state_d = ST_PUSH;
        end else begin
          cmd_o.ptr_inc = 1'b1;
          state_d       = ST_RD;
        end
      end
      ST_SH_RD: begin
        cmd_o.rd_prev = 1'b1;
        state_d       = ST_SH_WR;
      end
      ST_SH_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.ptr_dec  = 1'b1;
        state_d        = status_i.ptr_one ? ST_FRONT : ST_SH_RD;
      end
      ST_FRONT: begin
        cmd_o.wr_front = 1'b1;
        state_d        = ST_PUSH;
      end
      ST_PUSH: begin
        if (slot_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

### hdl/move_to_front_search_list.sv
`default_nettype none

// Move-to-front list of signed 32-bit keys held in a single-port-write,
// single-read RAM of LIST_DEPTH entries. A load (kind 0) appends its key or,
// on a full list, flags load_rejected; a search (kind 1) scans the filled
// entries from position 0, reports the first hit position and then moves that
// entry to the front, shifting the entries ahead of it back by one. One item
// is in work at a time: a load is latched, dispatched and then handed to the
// output; a search reads and compares one entry at a time, as every RAM read
// is registered, until a hit or a miss after the last filled entry (an empty
// list goes straight to the output), and the move then shifts one entry at a
// time, as each entry shifted needs one read and one write.
// The finished result sits in an output register, so it may wait on the
// consumer while the next item is accepted.

module move_to_front_search_list (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire                             in_kind_i,
  input  wire signed [mtf_pkg::KEY_W-1:0] in_key_value_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic                            out_found_o,
  output logic [mtf_pkg::POS_W-1:0]       out_hit_position_o,
  output logic                            out_load_rejected_o
);

  mtf_pkg::cmd_t    cmd;
  mtf_pkg::status_t status;

  mtf_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mtf_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .in_kind_i           (in_kind_i),
    .in_key_value_i      (in_key_value_i),
    .out_found_o         (out_found_o),
    .out_hit_position_o  (out_hit_position_o),
    .out_load_rejected_o (out_load_rejected_o)
  );

endmodule

`default_nettype wire
